/* rtl/rotation_matrix_to_quaternion_defines.svh */
// assertion macros for the rotation matrix to quaternion block
// depends on nothing; included by the top level
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef ASSERT_OFF
`define RMQ_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define RMQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define RMQ_ASSERT_IMPL(label, clk, rst_n, prop)
`define RMQ_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/rmq_pkg.sv */
// shared constants and types for the quaternion converter
// depends on nothing
package rmq_pkg;
    localparam int FRAC_BITS = 14;
    localparam int EW = 16;
    // branch codes
    typedef enum logic [1:0] {BR_TRACE = 2'd0, BR_X = 2'd1, BR_Y = 2'd2, BR_Z = 2'd3} branch_t;
endpackage

/* rtl/rotation_matrix_to_quaternion.sv */
// rotation matrix (Q2.14) to quaternion converter, top level
// uses rmq_pkg, rmq_sqrt, rmq_div and the assertion macro header
//
// Takes one matrix per clock whenever start is high; busy is tied low so every
// start is a transaction. Each result appears on the quat_* ports and div_fault
// for one cycle with done high, after stage 1, the root pipeline (FRAC_BITS+2 bits),
// the divider pipeline (FRAC_BITS+18 bits) and the output register. Results stay
// in order, and done cannot be held off by the receiver.
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
    output logic        done,
    output logic signed [15:0] quat_w, quat_x, quat_y, quat_z,
    output logic        div_fault
);
    localparam int FRAC_BITS = rmq_pkg::FRAC_BITS;
    localparam int SW = FRAC_BITS + 2;          // root bits
    localparam int IW = 2 * SW;                 // radicand bits
    localparam int NW = 18;                     // sums of two elements, signed
    localparam int DW = SW + 1;                 // 2*root
    localparam int QL = NW + FRAC_BITS + 2;     // divider latency
    localparam int DL = QL - 1;                 // delay to align root side

    assign busy = 1'b0;
    logic acc;
    assign acc = start && !busy;

    // stage 1: trace, branch choice, root argument, numerators
    logic                 v1_reg;
    rmq_pkg::branch_t     br1_reg;
    logic signed [18:0]   arg1_reg;
    logic signed [NW-1:0] na1_reg, nb1_reg, nc1_reg;
    logic signed [17:0]   tr;
    rmq_pkg::branch_t     br_next;
    logic signed [18:0]   arg_next;
    logic signed [NW-1:0] na_next, nb_next, nc_next;
    logic signed [18:0]   one;
    assign one = 19'sd1 <<< FRAC_BITS;

    always_comb
    begin
        tr = 18'(r00) + 18'(r11) + 18'(r22);
        if (tr > 0)
        begin
            br_next  = rmq_pkg::BR_TRACE;
            arg_next = one + 19'(tr);
            na_next  = NW'(r21) - NW'(r12);
            nb_next  = NW'(r02) - NW'(r20);
            nc_next  = NW'(r10) - NW'(r01);
        end
        else if (r00 > r11 && r00 > r22)
        begin
            br_next  = rmq_pkg::BR_X;
            arg_next = one + 19'(r00) - 19'(r11) - 19'(r22);
            na_next  = NW'(r21) - NW'(r12);
            nb_next  = NW'(r01) + NW'(r10);
            nc_next  = NW'(r02) + NW'(r20);
        end
        else if (r11 > r22)
        begin
            br_next  = rmq_pkg::BR_Y;
            arg_next = one + 19'(r11) - 19'(r00) - 19'(r22);
            na_next  = NW'(r02) - NW'(r20);
            nb_next  = NW'(r01) + NW'(r10);
            nc_next  = NW'(r12) + NW'(r21);
        end
        else
        begin
            br_next  = rmq_pkg::BR_Z;
            arg_next = one + 19'(r22) - 19'(r00) - 19'(r11);
            na_next  = NW'(r10) - NW'(r01);
            nb_next  = NW'(r02) + NW'(r20);
            nc_next  = NW'(r12) + NW'(r21);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= acc;
    end
    always_ff @(posedge clk)
    begin
        br1_reg  <= br_next;
        arg1_reg <= arg_next;
        na1_reg  <= na_next;
        nb1_reg  <= nb_next;
        nc1_reg  <= nc_next;
    end

    // stage 2: radicand, negative argument clamps to zero
    logic [IW-1:0] rad;
    assign rad = arg1_reg[18] ? '0 : (IW'(arg1_reg[17:0]) << FRAC_BITS);

    logic          sq_v;
    logic [SW-1:0] root;
    rmq_sqrt #(.IW(IW), .SW(SW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .in_valid(v1_reg), .radicand(rad),
        .out_valid(sq_v), .root(root)
    );

    // side data delayed to match the root
    rmq_pkg::branch_t     brd_reg [SW+1];
    logic signed [NW-1:0] nad_reg [SW+1], nbd_reg [SW+1], ncd_reg [SW+1];
    always_ff @(posedge clk)
    begin
        brd_reg[0] <= br1_reg;
        nad_reg[0] <= na1_reg;
        nbd_reg[0] <= nb1_reg;
        ncd_reg[0] <= nc1_reg;
        for (int i = 0; i < SW; i++)
        begin
            brd_reg[i+1] <= brd_reg[i];
            nad_reg[i+1] <= nad_reg[i];
            nbd_reg[i+1] <= nbd_reg[i];
            ncd_reg[i+1] <= ncd_reg[i];
        end
    end

    logic [DW-1:0] den;
    assign den = {root, 1'b0};

    logic signed [15:0] qa, qb, qc;
    rmq_div #(.FB(FRAC_BITS), .NW(NW), .DW(DW)) u_div_a (
        .clk(clk), .num(nad_reg[SW]), .den(den), .quo(qa));
    rmq_div #(.FB(FRAC_BITS), .NW(NW), .DW(DW)) u_div_b (
        .clk(clk), .num(nbd_reg[SW]), .den(den), .quo(qb));
    rmq_div #(.FB(FRAC_BITS), .NW(NW), .DW(DW)) u_div_c (
        .clk(clk), .num(ncd_reg[SW]), .den(den), .quo(qc));

    // root, branch and valid delayed across the divider
    logic [QL-1:0]     vq_reg;
    rmq_pkg::branch_t  brq_reg [QL];
    logic [SW-1:0]     rtq_reg [QL];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg <= '0;
        else
            vq_reg <= {vq_reg[QL-2:0], sq_v};
    end
    always_ff @(posedge clk)
    begin
        brq_reg[0] <= brd_reg[SW];
        rtq_reg[0] <= root;
        for (int i = 0; i < QL - 1; i++)
        begin
            brq_reg[i+1] <= brq_reg[i];
            rtq_reg[i+1] <= rtq_reg[i];
        end
    end

    // output stage: place components by branch, or zero them all on a divide fault
    logic               done_reg;
    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    logic               f_reg;
    logic signed [15:0] half, w_next, x_next, y_next, z_next;
    logic               f_next;
    logic [SW-1:0]      rt;
    rmq_pkg::branch_t   bo;

    always_comb
    begin
        rt   = rtq_reg[DL];
        bo   = brq_reg[DL];
        half = ((rt >> 1) > SW'(32767)) ? 16'sh7fff : 16'(rt >> 1);
        f_next = (bo != rmq_pkg::BR_TRACE) && (rt == '0);
        case (bo)
            rmq_pkg::BR_TRACE:
            begin
                w_next = half; x_next = qa; y_next = qb; z_next = qc;
            end
            rmq_pkg::BR_X:
            begin
                w_next = qa; x_next = half; y_next = qb; z_next = qc;
            end
            rmq_pkg::BR_Y:
            begin
                w_next = qa; x_next = qb; y_next = half; z_next = qc;
            end
            default:
            begin
                w_next = qa; x_next = qb; y_next = qc; z_next = half;
            end
        endcase
        if (f_next)
        begin
            w_next = '0; x_next = '0; y_next = '0; z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vq_reg[DL];
    end
    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        f_reg <= f_next;
    end

    assign done      = done_reg;
    assign quat_w    = w_reg;
    assign quat_x    = x_reg;
    assign quat_y    = y_reg;
    assign quat_z    = z_reg;
    assign div_fault = f_reg;

    `RMQ_ASSERT_NEXT(a_fault_zero, clk, rst_n, vq_reg[DL] && f_next, div_fault && quat_w == 16'sd0 && quat_x == 16'sd0)
    `RMQ_ASSERT_NEXT(a_trace_ok, clk, rst_n, vq_reg[DL] && bo == rmq_pkg::BR_TRACE, !div_fault)
    `RMQ_ASSERT_NEXT(a_root_valid, clk, rst_n, sq_v, vq_reg[0])
endmodule

/* rtl/rmq_sqrt.sv */
// pipelined restoring square root, one result bit per stage
// depends on nothing
module rmq_sqrt #(
    parameter int IW = 32,
    parameter int SW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [IW-1:0] radicand,
    output logic          out_valid,
    output logic [SW-1:0] root
);
    localparam int RW = SW + 2;
    logic [SW:0]   vld_reg;
    logic [IW-1:0] rad_reg [SW+1];
    logic [RW-1:0] rem_reg [SW+1];
    logic [SW-1:0] q_reg   [SW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[SW-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        rad_reg[0] <= radicand;
        rem_reg[0] <= '0;
        q_reg[0]   <= '0;
    end

    for (genvar i = 0; i < SW; i++) begin : g_st
        logic [RW-1:0] rem_next;
        logic [RW-1:0] trial;
        logic [RW-1:0] two_bits;
        always_comb
        begin
            two_bits = RW'(rad_reg[i][2*(SW-1-i) +: 2]);
            rem_next = {rem_reg[i][RW-3:0], 2'b00} | two_bits;
            trial    = {q_reg[i], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            rad_reg[i+1] <= rad_reg[i];
            if (rem_next >= trial) begin
                rem_reg[i+1] <= rem_next - trial;
                q_reg[i+1]   <= {q_reg[i][SW-2:0], 1'b1};
            end else begin
                rem_reg[i+1] <= rem_next;
                q_reg[i+1]   <= {q_reg[i][SW-2:0], 1'b0};
            end
        end
    end

    assign out_valid = vld_reg[SW];
    assign root      = q_reg[SW];
endmodule

/* rtl/rmq_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturating to 16 bits
// depends on rmq_pkg
module rmq_div #(
    parameter int FB = rmq_pkg::FRAC_BITS,
    parameter int NW = 18,
    parameter int DW = 17
) (
    input  logic                 clk,
    input  logic signed [NW-1:0] num,
    input  logic        [DW-1:0] den,
    output logic signed [rmq_pkg::EW-1:0] quo
);
    // quotient bits needed: magnitude up to 2^(NW-1+FB); keep QW bits, saturate above
    localparam int QW = NW + FB;
    localparam int PW = DW + 1;
    logic [QW-1:0] mag_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [PW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic          neg_reg [QW+1];
    logic [NW-1:0] abs_num;

    assign abs_num = num[NW-1] ? NW'(-num) : num;

    always_ff @(posedge clk)
    begin
        mag_reg[0] <= {abs_num, FB'(0)};
        q_reg[0]   <= '0;
        rem_reg[0] <= '0;
        den_reg[0] <= den;
        neg_reg[0] <= num[NW-1];
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_st
        logic [PW-1:0] r;
        assign r = {rem_reg[i][PW-2:0], mag_reg[i][QW-1-i]};
        always_ff @(posedge clk)
        begin
            mag_reg[i+1] <= mag_reg[i];
            den_reg[i+1] <= den_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            if (r >= PW'(den_reg[i]))
            begin
                rem_reg[i+1] <= r - PW'(den_reg[i]);
                q_reg[i+1]   <= {q_reg[i][QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i+1] <= r;
                q_reg[i+1]   <= {q_reg[i][QW-2:0], 1'b0};
            end
        end
    end

    logic signed [rmq_pkg::EW-1:0] sat_reg;
    always_ff @(posedge clk)
    begin
        if (neg_reg[QW])
            sat_reg <= (q_reg[QW] > QW'(32768)) ? 16'sh8000 : rmq_pkg::EW'(-q_reg[QW]);
        else
            sat_reg <= (q_reg[QW] > QW'(32767)) ? 16'sh7fff : rmq_pkg::EW'(q_reg[QW]);
    end
    assign quo = sat_reg;
endmodule

/* tb/tb_rotation_matrix_to_quaternion.sv */
// testbench for the rotation matrix to quaternion converter
// drives matrix commands, predicts quaternions in fixed point or uses typed expectations, checks done results
// depends on rmq_pkg and rotation_matrix_to_quaternion
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
    localparam int FRAC_BITS = rmq_pkg::FRAC_BITS;
    localparam int LATENCY = 2 + (FRAC_BITS + 2) + (FRAC_BITS + 18) + 2;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM = 1000;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               fault;
    } quat_t;

    typedef struct {
        logic signed [15:0] e[9];
        bit                 typed;
        quat_t              q;
    } matrix_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    logic signed [15:0] elem[9];
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic div_fault;

    quat_t pending_quats[$];
    int errors = 0;
    int idle_cycles = 0;
    bit accepted_now;

    initial for (int i = 0; i < 9; i++) elem[i] = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rotation_matrix_to_quaternion u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .r00(elem[0]), .r01(elem[1]), .r02(elem[2]),
        .r10(elem[3]), .r11(elem[4]), .r12(elem[5]),
        .r20(elem[6]), .r21(elem[7]), .r22(elem[8]),
        .done(done), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y),
        .quat_z(quat_z), .div_fault(div_fault)
    );

    function automatic longint sat_q(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // floor(sqrt(a * 2^FRAC_BITS)), zero for a non-positive argument
    function automatic longint fixed_root(longint a);
        longint v, res, b;
        if (a <= 0) return 0;
        v = a <<< FRAC_BITS;
        res = 0;
        b = longint'(1) <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint fixed_quot(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< FRAC_BITS) / den;
        if (num < 0) return (q > 32768) ? -32768 : -q;
        return (q > 32767) ? 32767 : q;
    endfunction

    function automatic quat_t predict_quat(logic signed [15:0] e[9]);
        longint m[9];
        longint one, tr, s, den, w, x, y, z;
        quat_t q;
        for (int i = 0; i < 9; i++) m[i] = longint'(e[i]);
        one = longint'(1) <<< FRAC_BITS;
        tr = m[0] + m[4] + m[8];
        w = 0; x = 0; y = 0; z = 0;
        q.fault = 1'b0;
        if (tr > 0)
        begin
            s = fixed_root(one + tr);
            den = s <<< 1;
            w = sat_q(s >>> 1);
            x = fixed_quot(m[7] - m[5], den);
            y = fixed_quot(m[2] - m[6], den);
            z = fixed_quot(m[3] - m[1], den);
        end
        else if (m[0] > m[4] && m[0] > m[8])
        begin
            s = fixed_root(one + m[0] - m[4] - m[8]);
            den = s <<< 1;
            if (den == 0) q.fault = 1'b1;
            else
            begin
                w = fixed_quot(m[7] - m[5], den);
                x = sat_q(s >>> 1);
                y = fixed_quot(m[1] + m[3], den);
                z = fixed_quot(m[2] + m[6], den);
            end
        end
        else if (m[4] > m[8])
        begin
            s = fixed_root(one + m[4] - m[0] - m[8]);
            den = s <<< 1;
            if (den == 0) q.fault = 1'b1;
            else
            begin
                w = fixed_quot(m[2] - m[6], den);
                x = fixed_quot(m[1] + m[3], den);
                y = sat_q(s >>> 1);
                z = fixed_quot(m[5] + m[7], den);
            end
        end
        else
        begin
            s = fixed_root(one + m[8] - m[0] - m[4]);
            den = s <<< 1;
            if (den == 0) q.fault = 1'b1;
            else
            begin
                w = fixed_quot(m[3] - m[1], den);
                x = fixed_quot(m[2] + m[6], den);
                y = fixed_quot(m[5] + m[7], den);
                z = sat_q(s >>> 1);
            end
        end
        q.w = w[15:0];
        q.x = x[15:0];
        q.y = y[15:0];
        q.z = z[15:0];
        return q;
    endfunction

    // one transaction: hold start until accepted, then queue the expected quaternion
    task automatic send_matrix(matrix_row_t r);
        bit taken;
        @(negedge clk);
        for (int i = 0; i < 9; i++) elem[i] <= r.e[i];
        start <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken = 1'b1;
                pending_quats.push_back(r.typed ? r.q : predict_quat(r.e));
            end
        end
    endtask

    task automatic release_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    function automatic matrix_row_t make_row(int d0, int d1, int d2, bit typed, quat_t q);
        matrix_row_t r;
        for (int i = 0; i < 9; i++) r.e[i] = '0;
        r.e[0] = d0[15:0];
        r.e[4] = d1[15:0];
        r.e[8] = d2[15:0];
        r.typed = typed;
        r.q = q;
        return r;
    endfunction

    function automatic matrix_row_t random_row();
        matrix_row_t r;
        int kind, axis;
        r.typed = 1'b0;
        r.q = '0;
        kind = $urandom_range(0, 3);
        axis = $urandom_range(0, 2);
        for (int i = 0; i < 9; i++)
        begin
            case (kind)
                0: r.e[i] = $urandom;
                1: r.e[i] = $urandom_range(0, 32767) - 16384;
                default: r.e[i] = $urandom_range(0, 4096) - 2048;
            endcase
        end
        // near-rotation shapes: kind 2 has one dominant diagonal element, kind 3 three large ones
        if (kind == 2)
        begin
            r.e[axis * 4] = 16384 - $urandom_range(0, 1024);
            r.e[((axis + 1) % 3) * 4] = -16384 + $urandom_range(0, 1024);
            r.e[((axis + 2) % 3) * 4] = -16384 + $urandom_range(0, 1024);
        end
        else if (kind == 3)
        begin
            for (int i = 0; i < 3; i++) r.e[i * 4] = 16384 - $urandom_range(0, 8192);
        end
        return r;
    endfunction

    matrix_row_t directed_rows[$];

    initial
    begin
        quat_t q0;
        q0 = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        q0.w = 16384;
        directed_rows.push_back(make_row(16384, 16384, 16384, 1'b1, q0));
        q0 = '0; q0.z = 8192;
        directed_rows.push_back(make_row(0, 0, 0, 1'b1, q0));
        q0 = '0; q0.x = 16384;
        directed_rows.push_back(make_row(16384, -16384, -16384, 1'b1, q0));
        q0 = '0; q0.y = 16384;
        directed_rows.push_back(make_row(-16384, 16384, -16384, 1'b1, q0));
        q0 = '0; q0.z = 16384;
        directed_rows.push_back(make_row(-16384, -16384, 16384, 1'b1, q0));
        // ties on the diagonal, extremes and saturating off-diagonal terms
        directed_rows.push_back(make_row(-100, -100, -200, 1'b0, q0));
        directed_rows.push_back(make_row(-100, -200, -200, 1'b0, q0));
        directed_rows.push_back(make_row(-32768, -32768, -32768, 1'b0, q0));
        directed_rows.push_back(make_row(32767, 32767, 32767, 1'b0, q0));
        directed_rows.push_back(make_row(32767, -32768, -32768, 1'b0, q0));
        for (int k = 0; k < 6; k++)
        begin
            matrix_row_t r;
            r = make_row(-32768 + k, 32767 - k, -k * 5000, 1'b0, q0);
            for (int i = 0; i < 9; i++)
                if (i % 4 != 0) r.e[i] = (k % 2) ? 16'sh7fff : 16'sh8000;
            directed_rows.push_back(r);
        end
        foreach (directed_rows[i]) send_matrix(directed_rows[i]);
        release_start();

        for (int n = 0; n < N_RANDOM; )
        begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) send_matrix(random_row());
            release_start();
            if (n > N_RANDOM / 2 && n - burst <= N_RANDOM / 2)
                wait (pending_quats.size() == 0);
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end

        wait (pending_quats.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        quat_t exp_q;
        accepted_now = (start && !busy) || done;
        if (done)
        begin
            if (pending_quats.size() == 0)
            begin
                $display("%0t unexpected result w=%0d x=%0d y=%0d z=%0d f=%0b",
                         $time, quat_w, quat_x, quat_y, quat_z, div_fault);
                errors++;
            end
            else
            begin
                exp_q = pending_quats.pop_front();
                if (quat_w !== exp_q.w)
                begin
                    $display("%0t quat_w expected %0d actual %0d", $time, exp_q.w, quat_w);
                    errors++;
                end
                if (quat_x !== exp_q.x)
                begin
                    $display("%0t quat_x expected %0d actual %0d", $time, exp_q.x, quat_x);
                    errors++;
                end
                if (quat_y !== exp_q.y)
                begin
                    $display("%0t quat_y expected %0d actual %0d", $time, exp_q.y, quat_y);
                    errors++;
                end
                if (quat_z !== exp_q.z)
                begin
                    $display("%0t quat_z expected %0d actual %0d", $time, exp_q.z, quat_z);
                    errors++;
                end
                if (div_fault !== exp_q.fault)
                begin
                    $display("%0t div_fault expected %0b actual %0b",
                             $time, exp_q.fault, div_fault);
                    errors++;
                end
            end
        end
        // watchdog on cycles with no transaction either way
        if (accepted_now || !rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
tb/tb_rotation_matrix_to_quaternion.sv
